/* rtl/double_ended_queue_macros.svh */
// Assertion macros used by the double-ended queue top level.
// Needs nothing else; included by the top level, the only file that carries assertions.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dq_pkg.sv */
// Shared types and codes of the double-ended queue.
// Used by the controller, the datapath and the top level.
package dq_pkg;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_DUMP       = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic       dump_start;
      logic       dump_step;
      logic       load_direct;
      logic [1:0] direct_status;
      logic       load_mem;
      logic       mem_last;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic out_free;
      logic dump_last;
   } dp_status_type;

endpackage

/* rtl/dq_ctrl.sv */
// Controller of the double-ended queue: decodes each request and sequences
// pops and dumps. Depends on dq_pkg.
module dq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [2:0]            req_op,
   input  dq_pkg::dp_status_type status,
   output logic                  req_stall,
   output dq_pkg::cmd_type       cmd
);
   import dq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_POP  = 3'b010,
      ST_DUMP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = !((state_ff == ST_IDLE) && status.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op) inside
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     cmd.load_direct = 1'b1;
                     if (status.full) begin
                        cmd.direct_status = STATUS_FULL;
                     end else begin
                        cmd.direct_status = STATUS_OK;
                        cmd.push_front    = (req_op == OP_PUSH_FRONT);
                        cmd.push_back     = (req_op == OP_PUSH_BACK);
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     if (status.empty) begin
                        cmd.load_direct   = 1'b1;
                        cmd.direct_status = STATUS_EMPTY;
                     end else begin
                        cmd.pop_front = (req_op == OP_POP_FRONT);
                        cmd.pop_back  = (req_op == OP_POP_BACK);
                        state_in      = ST_POP;
                     end
                  end
                  OP_DUMP: begin
                     if (status.empty) begin
                        cmd.load_direct   = 1'b1;
                        cmd.direct_status = STATUS_EMPTY;
                     end else begin
                        cmd.dump_start = 1'b1;
                        state_in       = ST_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            cmd.load_mem = 1'b1;
            cmd.mem_last = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_DUMP: begin
            if (status.out_free) begin
               cmd.load_mem = 1'b1;
               cmd.mem_last = status.dump_last;
               if (status.dump_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.dump_step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/dq_datapath.sv */
// Datapath of the double-ended queue: element memory, front pointer, fill
// count, dump walker and result register. Depends on dq_pkg.
module dq_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dq_pkg::cmd_type       cmd,
   input  logic signed [31:0]    req_value,
   input  logic                  rsp_stall,
   output dq_pkg::dp_status_type status,
   output logic                  rsp_valid,
   output dq_pkg::rsp_type       rsp_item
);
   import dq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
   localparam logic [AW:0]   CAP_SUM   = (AW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_COUNT = CW'(1);

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
      wrap_inc = (a == LAST_SLOT) ? '0 : a + AW'(1);
   endfunction

   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
      wrap_dec = (a == '0) ? LAST_SLOT : a - AW'(1);
   endfunction

   function automatic logic [AW-1:0] wrap_sum(input logic [AW:0] s);
      logic [AW:0] r;
      r = (s >= CAP_SUM) ? s - CAP_SUM : s;
      wrap_sum = r[AW-1:0];
   endfunction

   logic signed [31:0] mem [CAPACITY];
   logic signed [31:0] mem_q_ff;

   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] walk_ff, walk_in;
   logic [CW-1:0] dump_left_ff, dump_left_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [AW:0]   tail_sum;
   logic [AW-1:0] back_slot;
   logic [AW-1:0] last_slot;
   logic [AW-1:0] front_dec;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   assign tail_sum  = {1'b0, front_ff} + (AW + 1)'(count_ff);
   assign back_slot = wrap_sum(tail_sum);
   assign last_slot = wrap_sum(tail_sum - (AW + 1)'(1));
   assign front_dec = wrap_dec(front_ff);

   assign status.empty     = (count_ff == '0);
   assign status.full      = (count_ff >= CAP_COUNT);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.dump_last = (dump_left_ff == ONE_COUNT);

   assign wr_en   = cmd.push_front || cmd.push_back;
   assign wr_addr = cmd.push_front ? front_dec : back_slot;
   assign rd_en   = cmd.pop_front || cmd.pop_back || cmd.dump_start || cmd.dump_step;

   always_comb begin
      if (cmd.pop_back) begin
         rd_addr = last_slot;
      end else if (cmd.dump_step) begin
         rd_addr = walk_ff;
      end else begin
         rd_addr = front_ff;
      end
   end

   always_comb begin
      front_in     = front_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      dump_left_in = dump_left_ff;
      if (cmd.push_front) begin
         front_in = front_dec;
         count_in = count_ff + ONE_COUNT;
      end
      if (cmd.push_back) begin
         count_in = count_ff + ONE_COUNT;
      end
      if (cmd.pop_front) begin
         front_in = wrap_inc(front_ff);
         count_in = count_ff - ONE_COUNT;
      end
      if (cmd.pop_back) begin
         count_in = count_ff - ONE_COUNT;
      end
      if (cmd.dump_start) begin
         walk_in      = wrap_inc(front_ff);
         dump_left_in = count_ff;
      end
      if (cmd.dump_step) begin
         walk_in      = wrap_inc(walk_ff);
         dump_left_in = dump_left_ff - ONE_COUNT;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_direct) begin
         rsp_in.status = cmd.direct_status;
         rsp_in.data   = '0;
         rsp_in.last   = 1'b1;
         rsp_valid_in  = 1'b1;
      end else if (cmd.load_mem) begin
         rsp_in.status = STATUS_OK;
         rsp_in.data   = mem_q_ff;
         rsp_in.last   = cmd.mem_last;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_value;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* rtl/double_ended_queue.sv */
// Top level of the double-ended queue: controller, datapath and checks.
// Depends on dq_pkg, dq_ctrl, dq_datapath and double_ended_queue_macros.svh.
// A push, a pop on an empty queue and a dump of an empty queue each give one
// result straight from the output register; a pop reads the element memory
// through its one registered read port before loading the output register; a
// dump of n elements streams one element per cycle through that same port
// while the output register is not stalled, front to back, with last set on
// the final element. A new request is taken once the controller is idle and
// the output register is empty or its transfer completes in that cycle. A push
// into a full queue is dropped with full status; the store is not cleared at
// reset, so no clearing pass is needed and the block is ready once reset falls.
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
   parameter int CAPACITY = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  dq_pkg::req_type req_item,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output dq_pkg::rsp_type rsp_item
);
   import dq_pkg::*;

   cmd_type       cmd;
   dp_status_type status;
   logic          req_transfer;

   assign req_transfer = req_valid && !req_stall;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_item.op),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   dq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_value (req_item.value),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   `DQ_ASSERT_NOW(a_load_needs_free, clock, reset, cmd.load_direct || cmd.load_mem, status.out_free, "result loaded over a pending transfer")
   `DQ_ASSERT_NEXT(a_full_push_dropped, clock, reset, req_transfer && status.full && (req_item.op == OP_PUSH_FRONT || req_item.op == OP_PUSH_BACK), status.full && rsp_valid && rsp_item.status == STATUS_FULL, "push into a full queue was not dropped")
   `DQ_ASSERT_NEXT(a_empty_pop_status, clock, reset, req_transfer && status.empty && (req_item.op == OP_POP_FRONT || req_item.op == OP_POP_BACK), rsp_valid && rsp_item.status == STATUS_EMPTY && rsp_item.last, "pop on an empty queue did not report empty")

endmodule

/* bench/testbench.sv */
// Self-checking bench for the double-ended queue: a software copy of the queue predicts every
// result, and the results are compared in order under several patterns of idling and stalling.
// Depends on dq_pkg and the double_ended_queue top level only.
module testbench;
   import dq_pkg::*;

   localparam int QUEUE_DEPTH = 64;
   localparam int SETTLE_CYCLES = 80;
   localparam int ITEMS_PER_PHASE = 110;
   localparam int REPORT_LIMIT = 10;
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST = 3'd7;
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

   class deque_mirror;
      logic signed [31:0] slots [QUEUE_DEPTH];
      int unsigned head = 0;
      int unsigned fill = 0;
      rsp_type awaited_results [$];
      int unsigned mismatches = 0;
      int unsigned compared = 0;
      int unsigned dumps = 0;
      int unsigned full_hits = 0;
      int unsigned empty_hits = 0;

      function void add_result(logic [1:0] status, logic signed [31:0] data, logic last);
         rsp_type r;
         r.status = status;
         r.data = data;
         r.last = last;
         awaited_results.push_back(r);
         if (status == STATUS_EMPTY) empty_hits++;
         if (status == STATUS_FULL) full_hits++;
      endfunction

      function void apply_request(req_type r);
         logic signed [31:0] popped;
         int unsigned k;
         case (r.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (fill >= QUEUE_DEPTH) begin
                  add_result(STATUS_FULL, '0, 1'b1);
               end else begin
                  if (r.op == OP_PUSH_FRONT) begin
                     head = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                     slots[head] = r.value;
                  end else begin
                     slots[(head + fill) % QUEUE_DEPTH] = r.value;
                  end
                  fill++;
                  add_result(STATUS_OK, '0, 1'b1);
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (fill == 0) begin
                  add_result(STATUS_EMPTY, '0, 1'b1);
               end else begin
                  if (r.op == OP_POP_FRONT) begin
                     popped = slots[head];
                     head = (head + 1) % QUEUE_DEPTH;
                  end else begin
                     popped = slots[(head + fill - 1) % QUEUE_DEPTH];
                  end
                  fill--;
                  add_result(STATUS_OK, popped, 1'b1);
               end
            end
            OP_DUMP: begin
               dumps++;
               if (fill == 0) begin
                  add_result(STATUS_EMPTY, '0, 1'b1);
               end else begin
                  for (k = 0; k < fill; k++)
                     add_result(STATUS_OK, slots[(head + k) % QUEUE_DEPTH], k + 1 == fill);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Unexpected result: status %0d data %0d last %0d",
                        got.status, got.data, got.last);
            return;
         end
         want = awaited_results.pop_front();
         compared++;
         if (got.status !== want.status || got.data !== want.data || got.last !== want.last)
         begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Mismatch on result %0d: status %0d/%0d data %0d/%0d last %0d/%0d %s",
                        compared, got.status, want.status, got.data, want.data,
                        got.last, want.last, "(actual/expected)");
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_item;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned items_sent = 0;
   deque_mirror mirror = new();

   double_ended_queue #(.CAPACITY(QUEUE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) mirror.check_result(rsp_item);
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic issue(input logic [2:0] op, input logic signed [31:0] value);
      req_type r;
      r.op = op;
      r.value = value;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.apply_request(r);
      if (op <= OP_DUMP) items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (mirror.awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(7))
         0: return INT_MIN;
         1: return INT_MAX;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_op();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 2) return 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      if (roll < 26) return OP_PUSH_FRONT;
      if (roll < 50) return OP_PUSH_BACK;
      if (roll < 70) return OP_POP_FRONT;
      if (roll < 90) return OP_POP_BACK;
      return OP_DUMP;
   endfunction

   // Fills the queue to capacity, pushes past it, dumps it whole and empties it again.
   task automatic fill_and_empty();
      while (mirror.fill < QUEUE_DEPTH)
         issue($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
      issue(OP_PUSH_FRONT, pick_value());
      issue(OP_PUSH_BACK, pick_value());
      issue(OP_DUMP, pick_value());
      while (mirror.fill != 0)
         issue($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, pick_value());
      issue(OP_POP_BACK, pick_value());
      issue(OP_DUMP, pick_value());
   endtask

   initial begin
      #5_000_000;
      $display("Time limit reached with %0d results outstanding.",
               mirror.awaited_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int unsigned phase_target;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      issue(OP_DUMP, INT_MAX);
      issue(OP_POP_FRONT, INT_MIN);
      issue(OP_POP_BACK, -1);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) issue(3'(op), $urandom);
      issue(OP_PUSH_FRONT, INT_MIN);
      issue(OP_PUSH_BACK, INT_MAX);
      issue(OP_PUSH_FRONT, -1);
      issue(OP_PUSH_BACK, '0);
      issue(OP_PUSH_FRONT, 32'sd1);
      issue(OP_DUMP, '0);
      issue(OP_POP_FRONT, '0);
      issue(OP_POP_BACK, '0);
      issue(OP_POP_FRONT, '0);
      issue(OP_POP_BACK, '0);
      issue(OP_DUMP, -1);
      issue(OP_POP_BACK, '0);
      issue(OP_POP_FRONT, '0);
      issue(OP_PUSH_BACK, 32'sh5555_5555);
      issue(OP_PUSH_FRONT, 32'shaaaa_aaaa);
      issue(OP_POP_BACK, '0);
      issue(OP_POP_BACK, '0);
      issue(OP_DUMP, '0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         phase_target = items_sent + ITEMS_PER_PHASE;
         if (phase % 2 == 0) fill_and_empty();
         while (items_sent < phase_target) issue(pick_op(), pick_value());
         drain();
      end

      if (mirror.awaited_results.size() != 0) begin
         mirror.mismatches++;
         $display("%0d expected results never arrived.", mirror.awaited_results.size());
      end
      $display("Sent %0d requests including %0d dumps; checked %0d results, %0d of them empty",
               items_sent, mirror.dumps, mirror.compared, mirror.empty_hits);
      $display("and %0d full, under free running, sender gaps, receiver stalls and both.",
               mirror.full_hits);
      if (mirror.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches in total.", mirror.mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue.sv
bench/testbench.sv
